FILE: rtl/text_console_writer_unit_assert.svh
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Consequent must hold at the same edge as the antecedent
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold at the next edge after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int RADDR_W    = 11;
  localparam int LOC_W      = 11;
  localparam int CELL_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Cell contents
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]        TEXT_ATTR  = 8'h0F;
  localparam int                TAB_STOP   = 8;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BACKSPACE,
    OP_TAB,
    OP_RETURN,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [CHAR_W-1:0]   char_code;
    logic [RADDR_W-1:0]  read_address;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DONE,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK
  } back_state_t;

endpackage

FILE: rtl/tcw_front.sv
module tcw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]      in_cmd,
  input  logic [tcw_pkg::IN_DATA_W-1:0]  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tcw_pkg::op_t                   out_op
);

  logic         hold_valid;
  tcw_pkg::op_t hold_op;
  tcw_pkg::op_t op_dec;

  // Decode command and control character into an operation
  always_comb begin
    op_dec.char_code    = in_data[tcw_pkg::CHAR_W-1:0];
    op_dec.read_address = in_data[tcw_pkg::CHAR_W +: tcw_pkg::RADDR_W];
    unique case (in_cmd)
      tcw_pkg::CMD_PUT: begin
        unique case (in_data[tcw_pkg::CHAR_W-1:0])
          tcw_pkg::CH_BACKSPACE: op_dec.kind = tcw_pkg::OP_BACKSPACE;
          tcw_pkg::CH_TAB:       op_dec.kind = tcw_pkg::OP_TAB;
          tcw_pkg::CH_RETURN:    op_dec.kind = tcw_pkg::OP_RETURN;
          tcw_pkg::CH_LINEFEED:  op_dec.kind = tcw_pkg::OP_NEWLINE;
          default:               op_dec.kind = tcw_pkg::OP_PRINT;
        endcase
      end
      tcw_pkg::CMD_CLEAR: op_dec.kind = tcw_pkg::OP_CLEAR;
      tcw_pkg::CMD_READ:  op_dec.kind = tcw_pkg::OP_READ;
      default:            op_dec.kind = tcw_pkg::OP_NOP;
    endcase
  end

  // One-entry holding register toward the queue
  assign in_ready  = !hold_valid || out_ready;
  assign out_valid = hold_valid;
  assign out_op    = hold_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_op <= op_dec;
    end
  end

endmodule

FILE: rtl/tcw_queue.sv
module tcw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tcw_pkg::op_t in_op,
  output logic         out_valid,
  input  logic         out_ready,
  output tcw_pkg::op_t out_op
);

  tcw_pkg::op_t                slots [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tcw_pkg::QPTR_W:0]    count;
  logic                        push;
  logic                        pop;

  assign in_ready  = count != (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
  end

endmodule

FILE: rtl/tcw_back.sv
module tcw_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  tcw_pkg::op_t                 op,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::LOC_W-1:0]    out_loc,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell
);

  localparam int CW = tcw_pkg::COL_W + 1;
  localparam int RW = tcw_pkg::ROW_W + 1;
  localparam int AW = tcw_pkg::ADDR_W;

  tcw_pkg::back_state_t state, state_next;

  logic [tcw_pkg::COL_W-1:0]  col, col_next;
  logic [tcw_pkg::ROW_W-1:0]  row, row_next;
  logic [AW-1:0]              idx, idx_next;
  logic                       pend, pend_next;
  logic [AW-1:0]              wr_addr;
  logic                       is_read;
  logic                       rd_ok;
  logic [tcw_pkg::CELL_W-1:0] rd_data;
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

  logic                       take;
  logic                       emit;
  logic [AW-1:0]              cur_index;
  logic [CW-1:0]              col_ext;
  logic [RW-1:0]              row_ext;
  logic                       scroll;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;

  assign take      = (state == tcw_pkg::ST_IDLE) && op_valid;
  assign emit      = (state == tcw_pkg::ST_DONE) && (!out_valid || out_ready);
  assign op_ready  = state == tcw_pkg::ST_IDLE;
  assign cur_index = AW'(row) * AW'(tcw_pkg::COLUMNS) + AW'(col);

  // Cursor motion for put operations, then wrap and scroll check
  always_comb begin
    col_ext = {1'b0, col};
    row_ext = {1'b0, row};
    case (op.kind)
      tcw_pkg::OP_PRINT:     col_ext = col_ext + 1'b1;
      tcw_pkg::OP_BACKSPACE: if (col != '0) col_ext = col_ext - 1'b1;
      tcw_pkg::OP_TAB:       col_ext = (col_ext + CW'(tcw_pkg::TAB_STOP))
                                       & ~CW'(tcw_pkg::TAB_STOP - 1);
      tcw_pkg::OP_RETURN:    col_ext = '0;
      tcw_pkg::OP_NEWLINE: begin
        col_ext = '0;
        row_ext = row_ext + 1'b1;
      end
      default: ;
    endcase
    if (col_ext >= CW'(tcw_pkg::COLUMNS)) begin
      col_ext = '0;
      row_ext = row_ext + 1'b1;
    end
    scroll = row_ext >= RW'(tcw_pkg::ROWS);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (op_valid) begin
          case (op.kind) inside
            tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_BLANK;
            tcw_pkg::OP_READ, tcw_pkg::OP_NOP: state_next = tcw_pkg::ST_DONE;
            default: state_next = scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
          endcase
        end
      end
      tcw_pkg::ST_COPY: begin
        if (idx == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1)) begin
          state_next = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: state_next = tcw_pkg::ST_BLANK;
      tcw_pkg::ST_BLANK: begin
        if (idx == AW'(tcw_pkg::CELLS - 1)) begin
          state_next = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: if (emit) state_next = tcw_pkg::ST_IDLE;
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Memory controls, cursor and sweep counter
  always_comb begin
    col_next  = col;
    row_next  = row;
    idx_next  = idx;
    pend_next = pend;
    mem_we    = 1'b0;
    mem_waddr = cur_index;
    mem_wdata = tcw_pkg::BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = AW'(op.read_address);
    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (op_valid) begin
          idx_next  = '0;
          pend_next = 1'b0;
          case (op.kind)
            tcw_pkg::OP_CLEAR: begin
              col_next = '0;
              row_next = '0;
            end
            tcw_pkg::OP_READ: begin
              mem_re = 1'b1;
            end
            tcw_pkg::OP_NOP: ;
            default: begin
              col_next = col_ext[tcw_pkg::COL_W-1:0];
              row_next = scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                : row_ext[tcw_pkg::ROW_W-1:0];
              if (op.kind == tcw_pkg::OP_PRINT) begin
                mem_we    = 1'b1;
                mem_wdata = {tcw_pkg::TEXT_ATTR, op.char_code};
              end else if (op.kind == tcw_pkg::OP_BACKSPACE && col != '0) begin
                mem_we    = 1'b1;
                mem_waddr = cur_index - 1'b1;
              end
            end
          endcase
        end
      end
      tcw_pkg::ST_COPY: begin
        // read one row ahead, write back the word read last cycle
        mem_re    = 1'b1;
        mem_raddr = idx + AW'(tcw_pkg::COLUMNS);
        mem_we    = pend;
        mem_waddr = wr_addr;
        mem_wdata = rd_data;
        pend_next = 1'b1;
        idx_next  = idx + 1'b1;
      end
      tcw_pkg::ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr;
        mem_wdata = rd_data;
        pend_next = 1'b0;
        idx_next  = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        idx_next  = idx + 1'b1;
      end
      tcw_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_IDLE;
      col       <= '0;
      row       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      pend  <= pend_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == tcw_pkg::ST_COPY) begin
      wr_addr <= idx;
    end
    if (take) begin
      is_read <= op.kind == tcw_pkg::OP_READ;
      rd_ok   <= 32'(op.read_address) < tcw_pkg::CELLS;
    end
    if (emit) begin
      out_loc  <= tcw_pkg::LOC_W'(cur_index);
      out_cell <= (is_read && rd_ok) ? rd_data : '0;
    end
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule

FILE: rtl/text_console_writer_unit.sv
// Text console writer over an 80 x 25 store of 16-bit cells (attribute high,
// character low).
// Input stream s_axis: tuser carries the command (put, clear, read), tdata
// carries the character byte and the read address. Output stream m_axis
// returns exactly one result per command: the linear cursor position after
// the command and, for a read inside the store, the cell word (zero otherwise).
// A put without scroll, a read or an unused command passes the front
// register, the queue, the execute state and the result register.
// The back end takes no new command until its execute and result states
// have emitted the result of the last one.
// A put that scrolls makes 1920 cell copies through the memory's one read
// and one write port, a drain step and 80 blanking writes. A clear makes
// 2000 blanking writes.
// The front register and a 2-entry queue keep taking commands while the
// back end scrolls or clears, until they fill.
// Reset homes the cursor and empties the queue; the cell store is not
// cleared and must be written by a clear before any read.
// When the receiver stalls, the result waits in the output register and the
// back end holds before emitting the next result.
module text_console_writer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_code, [18:8] read_address, [23:19] zero
  input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] cmd
  input  logic [tcw_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [10:0] cursor_location, [26:11] cell_value, [31:27] zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  `include "text_console_writer_unit_assert.svh"

  logic                        f_valid;
  logic                        f_ready;
  tcw_pkg::op_t                f_op;
  logic                        q_valid;
  logic                        back_ready;
  tcw_pkg::op_t                q_op;
  logic [tcw_pkg::LOC_W-1:0]   out_loc;
  logic [tcw_pkg::CELL_W-1:0]  out_cell;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_op    (f_op)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (q_valid),
    .out_ready (back_ready),
    .out_op    (q_op)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op_ready  (back_ready),
    .op        (q_op),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_loc   (out_loc),
    .out_cell  (out_cell)
  );

  // Pack the result fields
  assign m_axis_tdata = {
    (tcw_pkg::OUT_DATA_W - tcw_pkg::LOC_W - tcw_pkg::CELL_W)'(0),
    out_cell,
    out_loc
  };

  // The cursor never leaves the screen
  `TCW_ASSERT_NOW(a_cursor_on_screen, m_axis_tvalid, 32'(m_axis_tdata[tcw_pkg::LOC_W-1:0]) < tcw_pkg::CELLS, "cursor beyond last cell")
  // The back end takes one command and is busy at least the following cycle
  `TCW_ASSERT_NEXT(a_single_take, q_valid && back_ready, !back_ready, "back end took two commands back to back")
  // No result comes out right after reset
  `TCW_ASSERT_NOW(a_quiet_after_reset, $past(rst), !m_axis_tvalid, "result present after reset")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  // Command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1450;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [RADDR_W-1:0] read_address;
  } console_cmd_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_value;
  } console_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  text_console_writer_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Commands waiting to be sent, expected results waiting to come back
  console_cmd_t    pending_cmds[$];
  console_result_t expected_results[$];
  int total_cmds = 0;

  // Shadow of the console: cell store and cursor
  logic [CELL_W-1:0] screen_model[CELLS];
  int cur_col = 0;
  int cur_row = 0;

  int accepted_count = 0;
  int result_count = 0;
  int error_count = 0;
  int put_count = 0;
  int clear_count = 0;
  int read_count = 0;
  int scroll_count = 0;

  // Sender burst/gap bookkeeping
  int burst_left = 1;
  int idle_left = 0;

  // Receiver stall pattern
  int rx_cycle = 0;
  int rx_mode = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one command to the shadow console and return what the block should answer
  function automatic console_result_t console_step(input console_cmd_t c);
    console_result_t r;
    int i;
    r.cell_value = '0;
    case (c.cmd)
      CMD_PUT: begin
        put_count++;
        case (c.char_code)
          CH_BACKSPACE: begin
            if (cur_col != 0) begin
              cur_col--;
              screen_model[cur_row * COLUMNS + cur_col] = BLANK_CELL;
            end
          end
          CH_TAB: cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
          CH_RETURN: cur_col = 0;
          CH_LINEFEED: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            screen_model[cur_row * COLUMNS + cur_col] = {TEXT_ATTR, c.char_code};
            cur_col++;
          end
        endcase
        // wrap at the right edge
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row past the bottom
        if (cur_row >= ROWS) begin
          scroll_count++;
          for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
          cur_row = ROWS - 1;
        end
      end
      CMD_CLEAR: begin
        clear_count++;
        for (i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        read_count++;
        if (c.read_address < CELLS) r.cell_value = screen_model[c.read_address];
      end
      default: ;
    endcase
    r.cursor_location = LOC_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic void queue_cmd(input logic [CMD_W-1:0] cmd,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [RADDR_W-1:0] addr);
    console_cmd_t c;
    c.cmd = cmd;
    c.char_code = ch;
    c.read_address = addr;
    pending_cmds.push_back(c);
  endfunction

  // Stimulus: directed opening, then random text sessions
  initial begin : stimulus
    int kind;
    int len;
    int k;
    int pick;
    logic [CHAR_W-1:0] ch;

    // Clear first so every later read hits a written cell
    queue_cmd(CMD_CLEAR, 8'h00, 11'd0);
    queue_cmd(CMD_READ, 8'hFF, 11'd0);
    queue_cmd(CMD_PUT, 8'h41, 11'd0);
    queue_cmd(CMD_PUT, 8'h00, 11'd0);
    queue_cmd(CMD_PUT, 8'hFF, 11'h7FF);
    queue_cmd(CMD_READ, 8'h00, 11'd1);
    queue_cmd(CMD_READ, 8'h00, 11'd2);
    queue_cmd(CMD_PUT, CH_BACKSPACE, 11'd0);
    queue_cmd(CMD_READ, 8'h00, 11'd2);
    queue_cmd(CMD_PUT, CH_TAB, 11'd0);
    queue_cmd(CMD_PUT, 8'h7E, 11'd0);
    queue_cmd(CMD_PUT, CH_RETURN, 11'd0);
    // backspace at column zero does nothing
    queue_cmd(CMD_PUT, CH_BACKSPACE, 11'd0);
    queue_cmd(CMD_PUT, CH_LINEFEED, 11'd0);
    queue_cmd(CMD_NONE, 8'hFF, 11'h7FF);
    queue_cmd(CMD_READ, 8'h00, 11'd1999);
    // out-of-range reads return zero
    queue_cmd(CMD_READ, 8'h00, 11'd2000);
    queue_cmd(CMD_READ, 8'hFF, 11'h7FF);
    queue_cmd(CMD_PUT, 8'h80, 11'd0);
    queue_cmd(CMD_READ, 8'h55, 11'd80);
    total_cmds = pending_cmds.size() + RANDOM_ITEMS;

    while (pending_cmds.size() < total_cmds) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        // a line of text, mostly printable, ending in a newline more often than not
        len = $urandom_range(1, 40);
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 84) ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
          else if (pick < 90) ch = CHAR_W'($urandom_range(0, 255));
          else if (pick < 93) ch = CH_BACKSPACE;
          else if (pick < 96) ch = CH_TAB;
          else if (pick < 98) ch = CH_RETURN;
          else ch = CH_LINEFEED;
          queue_cmd(CMD_PUT, ch, RADDR_W'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 9) < 7) queue_cmd(CMD_PUT, CH_LINEFEED, '0);
      end else if (kind < 86) begin
        // look back at a few cells, now and then past the end of the store
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) pick = $urandom_range(CELLS, 2047);
          else pick = $urandom_range(0, CELLS - 1);
          queue_cmd(CMD_READ, CHAR_W'($urandom_range(0, 255)), RADDR_W'(pick));
        end
      end else if (kind < 91) begin
        // run of newlines to push toward the bottom row
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) queue_cmd(CMD_PUT, CH_LINEFEED, '0);
      end else if (kind < 95) begin
        // run of tabs or backspaces
        len = $urandom_range(1, 12);
        ch = ($urandom_range(0, 1) == 0) ? CH_TAB : CH_BACKSPACE;
        for (k = 0; k < len; k++) queue_cmd(CMD_PUT, ch, '0);
      end else if (kind < 98) begin
        queue_cmd(CMD_NONE, CHAR_W'($urandom_range(0, 255)), RADDR_W'($urandom_range(0, 2047)));
      end else begin
        queue_cmd(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), RADDR_W'($urandom_range(0, 2047)));
      end
    end
    // trim overshoot of the last session
    while (pending_cmds.size() > total_cmds) void'(pending_cmds.pop_back());
  end

  // Reset
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) void'(pending_cmds.pop_front());
      if (idle_left > 0) begin
        idle_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, pending_cmds[0].read_address, pending_cmds[0].char_code};
        s_axis_tuser <= pending_cmds[0].cmd;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  // Receiver: ready follows one of four stall modes, picked anew at random
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_cycle % 9) < 6;
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : monitor
    console_cmd_t c;
    console_result_t want;
    console_result_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        c.cmd = s_axis_tuser;
        c.char_code = s_axis_tdata[7:0];
        c.read_address = s_axis_tdata[18:8];
        expected_results.push_back(console_step(c));
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        got.cursor_location = m_axis_tdata[10:0];
        got.cell_value = m_axis_tdata[26:11];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, cursor %0d cell %h", $time,
                   got.cursor_location, got.cell_value);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.cursor_location !== want.cursor_location) begin
            $display("%0t: result %0d cursor_location expected %0d actual %0d", $time,
                     result_count, want.cursor_location, got.cursor_location);
            error_count++;
          end
          if (got.cell_value !== want.cell_value) begin
            $display("%0t: result %0d cell_value expected %h actual %h", $time,
                     result_count, want.cell_value, got.cell_value);
            error_count++;
          end
        end
      end
    end
  end

  // End of run: all results in, then a short quiet period
  initial begin
    wait (total_cmds > 0);
    while (accepted_count < total_cmds || expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("Ran %0d commands: %0d puts, %0d clears, %0d reads, %0d scrolls.",
             accepted_count, put_count, clear_count, read_count, scroll_count);
    $display("Checked %0d results, %0d mismatches.", result_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(120_000_000);
    $display("%0t: timeout with %0d of %0d commands accepted", $time, accepted_count,
             total_cmds);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_unit.sv
tb/tb.sv
